>>> sv/rbs_pkg.sv
// Shared types and constants for the ray versus box slab test core.
// Used by rbs_div and ray_box_slab_intersect_core; depends on nothing.
package rbs_pkg;

  localparam int DATA_W = 32;
  // Quotient bits produced by the divider; anything at or above bit 33 saturates.
  localparam int Q_BITS = 33;
  // Divider stages: one setup stage, one stage per quotient bit, one saturation stage.
  localparam int DIV_LAT = Q_BITS + 2;

  localparam int NUM_REGS = 8;
  localparam int IDX_W = 4;

  typedef logic signed [DATA_W-1:0] fix_t;
  typedef logic [IDX_W-1:0] reg_idx_t;

  localparam fix_t FIX_MAX = fix_t'(32'sh7fff_ffff);
  localparam fix_t FIX_MIN = fix_t'(32'sh8000_0000);

  localparam reg_idx_t REG_ORG_X = 4'd0;
  localparam reg_idx_t REG_ORG_Y = 4'd1;
  localparam reg_idx_t REG_ORG_Z = 4'd2;
  localparam reg_idx_t REG_DIR_X = 4'd3;
  localparam reg_idx_t REG_DIR_Y = 4'd4;
  localparam reg_idx_t REG_DIR_Z = 4'd5;
  localparam reg_idx_t REG_T_MIN = 4'd6;
  localparam reg_idx_t REG_T_MAX = 4'd7;

endpackage

>>> sv/rbs_div.sv
// Pipelined restoring divider for one slab distance, one quotient bit per stage,
// with truncation toward zero and signed 32-bit saturation. Depends on rbs_pkg.
module rbs_div #(
  parameter int NUM_W = 48
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [NUM_W-1:0]           num,
  input  logic [rbs_pkg::DATA_W-1:0] den,
  input  logic                       neg,
  output rbs_pkg::fix_t              quot
);
  import rbs_pkg::*;

  localparam int HI_W = NUM_W - Q_BITS;

  logic [DATA_W-1:0] rem     [0:Q_BITS];
  logic [Q_BITS-1:0] low     [0:Q_BITS];
  logic [Q_BITS-1:0] qacc    [0:Q_BITS];
  logic              ovf     [0:Q_BITS];
  logic              neg_p   [0:Q_BITS];

  // The high part must be below the divisor for a 33-bit quotient to be exact;
  // otherwise the quotient is at least 2^33 and saturates regardless.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= DATA_W'(num[NUM_W-1:Q_BITS]);
      ovf[0]   <= ({{(DATA_W-HI_W){1'b0}}, num[NUM_W-1:Q_BITS]} >= den);
      low[0]   <= num[Q_BITS-1:0];
      qacc[0]  <= '0;
      neg_p[0] <= neg;
    end
  end

  for (genvar k = 0; k < Q_BITS; k++) begin : g_step
    logic [DATA_W:0]   trial;
    logic [DATA_W+1:0] sub;
    logic              ge;

    assign trial = {rem[k], low[k][Q_BITS-1]};
    assign sub   = {1'b0, trial} - {2'b00, den};
    assign ge    = ~sub[DATA_W+1];

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]   <= ge ? sub[DATA_W-1:0] : trial[DATA_W-1:0];
        low[k+1]   <= {low[k][Q_BITS-2:0], 1'b0};
        qacc[k+1]  <= {qacc[k][Q_BITS-2:0], ge};
        ovf[k+1]   <= ovf[k];
        neg_p[k+1] <= neg_p[k];
      end
    end
  end

  logic              big;
  logic [DATA_W-1:0] qlo;

  assign big = ovf[Q_BITS] | qacc[Q_BITS][Q_BITS-1];
  assign qlo = qacc[Q_BITS][DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_p[Q_BITS]) begin
        if (big || qlo > DATA_W'(33'h0_8000_0000)) begin
          quot <= FIX_MIN;
        end else begin
          quot <= fix_t'(-qlo);
        end
      end else begin
        if (big || qlo[DATA_W-1]) begin
          quot <= FIX_MAX;
        end else begin
          quot <= fix_t'(qlo);
        end
      end
    end
  end

endmodule

>>> sv/ray_box_slab_intersect_core.sv
// Ray versus axis-aligned box slab test core: configuration registers, entry
// stage, two rbs_div dividers per axis, and the interval merge. Uses rbs_pkg.
//
// The ray (origin, direction, t_min, t_max) is loaded through the configuration
// channel; the user must load it only while the core is idle, which the core
// does not enforce. Each box on the input stream yields one result of hit,
// t_enter and t_exit (all zero on a miss). One box is accepted every clock while
// the output is not stalled (a stall freezes the whole pipeline); each result
// passes one entry stage, the six slab-distance dividers and three merge stages.
module ray_box_slab_intersect_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // Box transaction, fields from bit 0: box_min_x, box_min_y, box_min_z,
  // box_max_x, box_max_y, box_max_z (32 bits each).
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [191:0]                  s_tdata,
  // Result transaction, fields from bit 0: hit (1), t_enter (32), t_exit (32),
  // then zero padding.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [71:0]                   m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  rbs_pkg::reg_idx_t             cfg_index,
  input  logic [rbs_pkg::DATA_W-1:0]    cfg_data
);
  import rbs_pkg::*;

  localparam int NUM_W = DATA_W + FRAC_BITS;
  localparam int LAST  = DIV_LAT + 3;

  fix_t regs [0:NUM_REGS-1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[REG_ORG_X[IDX_W-2:0]] <= '0;
      regs[REG_ORG_Y[IDX_W-2:0]] <= '0;
      regs[REG_ORG_Z[IDX_W-2:0]] <= '0;
      regs[REG_DIR_X[IDX_W-2:0]] <= fix_t'(32'sd65536);
      regs[REG_DIR_Y[IDX_W-2:0]] <= '0;
      regs[REG_DIR_Z[IDX_W-2:0]] <= '0;
      regs[REG_T_MIN[IDX_W-2:0]] <= '0;
      regs[REG_T_MAX[IDX_W-2:0]] <= FIX_MAX;
    end else if (cfg_valid && cfg_index < reg_idx_t'(NUM_REGS)) begin
      regs[cfg_index[IDX_W-2:0]] <= fix_t'(cfg_data);
    end
  end

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic vp   [0:LAST-1];
  logic zmiss[0:LAST-1];

  logic [2:0]  dz;
  fix_t        tn  [0:2];
  fix_t        tf  [0:2];
  logic        zm_ax [0:2];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    fix_t               org, dir, ca, cb, lo, hi;
    logic signed [DATA_W:0] da, db;
    logic [DATA_W-1:0]  dmag;
    logic [NUM_W-1:0]   num_a, num_b;
    logic               neg_a, neg_b;
    fix_t               qa, qb;

    assign org   = regs[a];
    assign dir   = regs[a+3];
    assign dz[a] = (dir == '0);
    assign dmag  = dir[DATA_W-1] ? DATA_W'(-dir) : DATA_W'(dir);
    assign ca    = fix_t'(s_tdata[a*DATA_W +: DATA_W]);
    assign cb    = fix_t'(s_tdata[(a+3)*DATA_W +: DATA_W]);
    assign lo    = (ca < cb) ? ca : cb;
    assign hi    = (ca < cb) ? cb : ca;
    assign zm_ax[a] = dz[a] && (org < lo || org > hi);
    assign da    = (DATA_W+1)'(ca) - (DATA_W+1)'(org);
    assign db    = (DATA_W+1)'(cb) - (DATA_W+1)'(org);

    // The distance magnitude fits 32 bits, so the shifted numerator is NUM_W bits.
    always_ff @(posedge clk) begin
      if (en) begin
        num_a <= {(da[DATA_W] ? DATA_W'(-da) : da[DATA_W-1:0]), {FRAC_BITS{1'b0}}};
        num_b <= {(db[DATA_W] ? DATA_W'(-db) : db[DATA_W-1:0]), {FRAC_BITS{1'b0}}};
        neg_a <= da[DATA_W] ^ dir[DATA_W-1];
        neg_b <= db[DATA_W] ^ dir[DATA_W-1];
      end
    end

    rbs_div #(.NUM_W(NUM_W)) u_div_a (
      .clk(clk), .en(en), .num(num_a), .den(dmag), .neg(neg_a), .quot(qa)
    );
    rbs_div #(.NUM_W(NUM_W)) u_div_b (
      .clk(clk), .en(en), .num(num_b), .den(dmag), .neg(neg_b), .quot(qb)
    );

    // An axis with zero direction places no bound on the interval.
    always_ff @(posedge clk) begin
      if (en) begin
        if (dz[a]) begin
          tn[a] <= FIX_MIN;
          tf[a] <= FIX_MAX;
        end else begin
          tn[a] <= (qa > qb) ? qb : qa;
          tf[a] <= (qa > qb) ? qa : qb;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAST; i++) vp[i] <= 1'b0;
    end else if (en) begin
      vp[0] <= s_tvalid;
      for (int i = 1; i < LAST; i++) vp[i] <= vp[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zmiss[0] <= zm_ax[0] | zm_ax[1] | zm_ax[2];
      for (int i = 1; i < LAST; i++) zmiss[i] <= zmiss[i-1];
    end
  end

  fix_t p0a, p0b, p1a, p1b;

  always_ff @(posedge clk) begin
    if (en) begin
      p0a <= (tn[0] > tn[1]) ? tn[0] : tn[1];
      p0b <= (tn[2] > regs[REG_T_MIN[IDX_W-2:0]]) ? tn[2] : regs[REG_T_MIN[IDX_W-2:0]];
      p1a <= (tf[0] < tf[1]) ? tf[0] : tf[1];
      p1b <= (tf[2] < regs[REG_T_MAX[IDX_W-2:0]]) ? tf[2] : regs[REG_T_MAX[IDX_W-2:0]];
    end
  end

  fix_t t0, t1;
  logic hit;
  assign t0  = (p0a > p0b) ? p0a : p0b;
  assign t1  = (p1a < p1b) ? p1a : p1b;
  assign hit = !zmiss[LAST-1] && !(t0 > t1);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vp[LAST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= hit ? {7'd0, t1, t0, 1'b1} : '0;
    end
  end

  a_hit_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> $signed(m_tdata[32:1]) <= $signed(m_tdata[64:33]))
    else $error("hit reported with entry after exit");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata == '0)
    else $error("miss reported with nonzero distances");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && !vp[0])
    else $error("pipeline valid after reset");

endmodule
